// File: hw/rtl/assert_macros.svh
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/msat_pkg.sv
// Types and constants shared by the alarm timer modules.
`default_nettype none

package msat_pkg;

    localparam int unsigned NUM_SLOTS_DEF = 16;
    localparam int unsigned TIME_W        = 64;
    localparam int unsigned SLOT_W        = 6;
    localparam int unsigned MASK_W        = 64;
    localparam int unsigned ID_W          = 8;
    localparam int unsigned OP_W          = 3;
    localparam int unsigned STATUS_W      = 2;
    localparam int unsigned NS_PER_US     = 1000;

    // Input operation codes
    localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
    localparam logic [OP_W-1:0] OP_CREATE_ABS = 3'd1;
    localparam logic [OP_W-1:0] OP_CREATE_REL = 3'd2;
    localparam logic [OP_W-1:0] OP_QUERY      = 3'd3;
    localparam logic [OP_W-1:0] OP_DESTROY    = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_PAST    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

    // Slot modes
    localparam logic [1:0] MODE_FREE    = 2'd0;
    localparam logic [1:0] MODE_ARMED   = 2'd1;
    localparam logic [1:0] MODE_EXPIRED = 2'd2;

    // Commands broadcast to the cells
    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_TICK    = 3'd1;
    localparam logic [2:0] CMD_CREATE  = 3'd2;
    localparam logic [2:0] CMD_QUERY   = 3'd3;
    localparam logic [2:0] CMD_DESTROY = 3'd4;

    typedef struct packed {
        logic [2:0]        code;
        logic [TIME_W-1:0] key;   // deadline for create
        logic [TIME_W-1:0] now;
        logic [ID_W-1:0]   id;
    } slot_cmd_t;

    // Token walking down the cell row, one cell per cycle
    typedef struct packed {
        logic              active;
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] left;
        logic [MASK_W-1:0] mask;
    } slot_tok_t;

endpackage

`default_nettype wire

// File: hw/rtl/msat_cell.sv
// One alarm slot: holds its mode and deadline, acts when the token passes.
`default_nettype none

module msat_cell
    import msat_pkg::*;
#(
    parameter int unsigned IDX = 0
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire slot_cmd_t cmd,
    input  wire slot_tok_t tok_in,
    output slot_tok_t      tok_out
);

    logic [1:0]        mode_reg, mode_next;
    logic [TIME_W-1:0] deadline_reg, deadline_next;
    slot_tok_t         tok_reg, tok_next;
    logic              due;
    logic              id_hit;
    logic              live;

    always_comb
    begin
        due           = (deadline_reg <= cmd.now);
        id_hit        = (cmd.id == ID_W'(IDX));
        live          = (mode_reg == MODE_ARMED) || (mode_reg == MODE_EXPIRED);
        mode_next     = mode_reg;
        deadline_next = deadline_reg;
        tok_next      = tok_in;
        if (tok_in.active)
        begin
            unique case (cmd.code) inside
                CMD_TICK:
                begin
                    if (mode_reg == MODE_ARMED && due)
                    begin
                        mode_next          = MODE_EXPIRED;
                        tok_next.mask[IDX] = 1'b1;
                    end
                end
                CMD_CREATE:
                begin
                    // first free cell along the row takes it
                    if (!tok_in.hit && !live)
                    begin
                        mode_next     = MODE_ARMED;
                        deadline_next = cmd.key;
                        tok_next.hit  = 1'b1;
                        tok_next.slot = SLOT_W'(IDX);
                    end
                end
                CMD_QUERY, CMD_DESTROY:
                begin
                    if (id_hit && live)
                    begin
                        tok_next.hit = 1'b1;
                        if (mode_reg == MODE_EXPIRED)
                            tok_next.left = '0;
                        else if (due)
                            tok_next.left = TIME_W'(1);
                        else
                            tok_next.left = deadline_reg - cmd.now;
                        if (cmd.code == CMD_DESTROY)
                            mode_next = MODE_FREE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_FREE;
            tok_reg  <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        deadline_reg <= deadline_next;
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// File: hw/rtl/multi_slot_alarm_timer.sv
// Top level of the multi-slot alarm timer: control, clock and cell row.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one word per operation: tick,
//   create absolute, create relative (microseconds), query, destroy.
//   Output channel (out_valid/out_ready) returns exactly one result word
//   per input word: status, allocated slot, time left, fired mask and the
//   clock value after the operation.
//   From input accept to out_valid the word passes the setup states S_MUL
//   (tick add / x1000 multiply), S_ADD (relative deadline add with
//   saturation) and S_CMP (past-deadline compare), then a token walks the
//   slot cell row one cell per clock, is captured, and is loaded into the
//   output register. One operation is in flight at a time, so a new word is
//   taken only once the previous result has entered the output register.
//   A new word is taken while the previous result still waits at the
//   output. If the receiver stalls, the finished result is held until the
//   output register frees up, and no further word is taken meanwhile.
//   Reset clears the clock to zero, frees every slot and empties the
//   output; no clearing pass is needed.
`default_nettype none

module multi_slot_alarm_timer
    import msat_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [OP_W-1:0]     op,
    input  wire logic [31:0]         tick_nanos,
    input  wire logic [TIME_W-1:0]   target_time,
    input  wire logic [31:0]         delay_us,
    input  wire logic [ID_W-1:0]     slot_id,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [STATUS_W-1:0]      status,
    output logic [SLOT_W-1:0]        slot,
    output logic [TIME_W-1:0]        remaining_ns,
    output logic [MASK_W-1:0]        fired_mask,
    output logic [TIME_W-1:0]        now
);

    localparam int unsigned PROD_W = 42;  // 32-bit us times 1000 fits 42 bits

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic                launch_reg, launch_next;
    logic                out_valid_reg, out_valid_next;
    logic [TIME_W-1:0]   now_reg, now_next;

    // latched input word
    logic [OP_W-1:0]     op_reg;
    logic [31:0]         nanos_reg;
    logic [TIME_W-1:0]   target_reg;
    logic [31:0]         delay_reg;
    logic [ID_W-1:0]     id_reg;

    // setup datapath
    logic [PROD_W-1:0]   prod_reg;
    logic [TIME_W-1:0]   key_reg;
    logic [TIME_W:0]     rel_sum;
    logic                past_reg;
    logic [2:0]          code_reg;
    logic [2:0]          code_next;
    logic                past_next;

    // captured result
    logic [STATUS_W-1:0] res_status_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic [TIME_W-1:0]   res_left_reg;
    logic [MASK_W-1:0]   res_mask_reg;
    logic [STATUS_W-1:0] res_status_next;

    // output register
    logic [STATUS_W-1:0] status_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [TIME_W-1:0]   left_reg;
    logic [MASK_W-1:0]   mask_reg;
    logic [TIME_W-1:0]   now_out_reg;

    slot_cmd_t           cmd;
    slot_tok_t           tok [0:NUM_SLOTS];

    logic                in_fire;
    logic                out_free;

    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    // relative deadline, saturating at all ones
    assign rel_sum = {1'b0, now_reg} + (TIME_W + 1)'(prod_reg);

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        launch_next    = 1'b0;
        out_valid_next = out_valid_reg;
        now_next       = now_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                if (op_reg == OP_TICK)
                    now_next = now_reg + TIME_W'(nanos_reg);  // wraps mod 2^64
                state_next = S_ADD;
            end
            S_ADD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                launch_next = 1'b1;
                state_next  = S_SCAN;
            end
            S_SCAN:
            begin
                if (tok[NUM_SLOTS].active)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            now_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
            now_reg       <= now_next;
        end
    end

    // ---------------------------------------------------------------
    // Command decode; a create whose deadline is past is dropped here
    // ---------------------------------------------------------------
    always_comb
    begin
        past_next = (key_reg < now_reg);
        unique case (op_reg) inside
            OP_TICK:                     code_next = CMD_TICK;
            OP_CREATE_ABS, OP_CREATE_REL: code_next = past_next ? CMD_NONE : CMD_CREATE;
            OP_QUERY:                    code_next = CMD_QUERY;
            OP_DESTROY:                  code_next = CMD_DESTROY;
            default:                     code_next = CMD_NONE;
        endcase
    end

    // Status from what came back along the row
    always_comb
    begin
        unique case (op_reg) inside
            OP_TICK:
                res_status_next = ST_OK;
            OP_CREATE_ABS, OP_CREATE_REL:
                res_status_next = past_reg ? ST_PAST :
                                  (tok[NUM_SLOTS].hit ? ST_OK : ST_FULL);
            OP_QUERY, OP_DESTROY:
                // an id past the table matches no cell
                res_status_next = tok[NUM_SLOTS].hit ? ST_OK : ST_INVALID;
            default:
                res_status_next = ST_INVALID;
        endcase
    end

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg     <= op;
            nanos_reg  <= tick_nanos;
            target_reg <= target_time;
            delay_reg  <= delay_us;
            id_reg     <= slot_id;
        end
        if (state_reg == S_MUL)
            prod_reg <= PROD_W'(delay_reg) * PROD_W'(NS_PER_US);
        if (state_reg == S_ADD)
        begin
            if (op_reg == OP_CREATE_REL)
                key_reg <= rel_sum[TIME_W] ? {TIME_W{1'b1}} : rel_sum[TIME_W-1:0];
            else
                key_reg <= target_reg;
        end
        if (state_reg == S_CMP)
        begin
            past_reg <= past_next;
            code_reg <= code_next;
        end
        if (state_reg == S_SCAN && tok[NUM_SLOTS].active)
        begin
            res_status_reg <= res_status_next;
            res_slot_reg   <= tok[NUM_SLOTS].slot;
            res_left_reg   <= tok[NUM_SLOTS].left;
            res_mask_reg   <= tok[NUM_SLOTS].mask;
        end
        if (state_reg == S_DONE && out_free)
        begin
            status_reg  <= res_status_reg;
            slot_reg    <= res_slot_reg;
            left_reg    <= res_left_reg;
            mask_reg    <= res_mask_reg;
            now_out_reg <= now_reg;
        end
    end

    // ---------------------------------------------------------------
    // Cell row: command is broadcast, token ripples cell to cell
    // ---------------------------------------------------------------
    assign cmd.code = code_reg;
    assign cmd.key  = key_reg;
    assign cmd.now  = now_reg;
    assign cmd.id   = id_reg;

    assign tok[0].active = launch_reg;
    assign tok[0].hit    = 1'b0;
    assign tok[0].slot   = '0;
    assign tok[0].left   = '0;
    assign tok[0].mask   = '0;

    for (genvar g = 0; g < NUM_SLOTS; g++)
    begin : g_cell
        msat_cell #(
            .IDX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (cmd),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign slot         = slot_reg;
    assign remaining_ns = left_reg;
    assign fired_mask   = mask_reg;
    assign now          = now_out_reg;

endmodule

`default_nettype wire

// File: hw/rtl/msat_checker.sv
// Port-level checks for the alarm timer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module msat_checker
    import msat_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire logic [STATUS_W-1:0] status,
    input wire logic [SLOT_W-1:0]   slot,
    input wire logic [TIME_W-1:0]   remaining_ns,
    input wire logic [MASK_W-1:0]   fired_mask,
    input wire logic [TIME_W-1:0]   now
);

    logic out_stall;
    logic in_take;
    logic mask_high_clear;

    assign out_stall       = out_valid && !out_ready;
    assign in_take         = in_valid && in_ready;
    assign mask_high_clear = ((fired_mask >> NUM_SLOTS) == '0);

    // stalled result word holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall,
        out_valid && $stable(status) && $stable(now) && $stable(remaining_ns),
        "stalled result changed")

    // one operation in flight
    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_take, !in_ready,
        "input taken while busy")

    // only a tick fires slots, and a tick reports nothing else
    `ASSERT_IMPLIES(a_mask_tick, clk, rst_n, out_valid && fired_mask != '0,
        status == ST_OK && remaining_ns == '0 && slot == '0 && mask_high_clear,
        "fired mask on a non-tick result")

    // failures carry no slot or time
    `ASSERT_IMPLIES(a_fail_clean, clk, rst_n, out_valid && status != ST_OK,
        slot == '0 && remaining_ns == '0 && fired_mask == '0,
        "failed result carries data")

endmodule

bind multi_slot_alarm_timer msat_checker #(
    .NUM_SLOTS (NUM_SLOTS)
) u_msat_checker (.*);

`default_nettype wire

// File: tb/multi_slot_alarm_timer_test.sv
// Self-checking testbench for the multi-slot alarm timer: directed, stall and random traffic.
`timescale 1ns / 100ps

module multi_slot_alarm_timer_test;
    import msat_pkg::*;

    localparam int unsigned SLOT_COUNT      = NUM_SLOTS_DEF;
    // Accept-to-result latency given by the top level.
    localparam int unsigned LATENCY         = SLOT_COUNT + 5;
    // Quiet cycles with no handshake on either side before giving up.
    // Worst correct stretch is the long output hold-off plus one latency.
    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned RANDOM_WORDS    = 1400;
    localparam int unsigned HOLD_OFF_CYCLES = 300;

    // Op codes beyond destroy have no name in the package; they are no-ops.
    localparam logic [OP_W-1:0] OP_UNDEF_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNDEF_MID   = 3'd6;
    localparam logic [OP_W-1:0] OP_UNDEF_LAST  = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [TIME_W-1:0]   left;
        logic [MASK_W-1:0]   mask;
        logic [TIME_W-1:0]   now;
    } alarm_result_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [OP_W-1:0]     op;
    logic [31:0]         tick_nanos;
    logic [TIME_W-1:0]   target_time;
    logic [31:0]         delay_us;
    logic [ID_W-1:0]     slot_id;
    logic                out_valid;
    logic                out_ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [TIME_W-1:0]   remaining_ns;
    logic [MASK_W-1:0]   fired_mask;
    logic [TIME_W-1:0]   now;

    // Shadow copy of the timer state, advanced once per accepted word.
    logic [TIME_W-1:0] clock_ns;
    logic [TIME_W-1:0] deadline_ns [SLOT_COUNT];
    logic [1:0]        slot_mode   [SLOT_COUNT];

    // Results still owed by the block, oldest first.
    alarm_result_t pending_results[$];

    int unsigned mismatch_count   = 0;
    bit          sender_gaps_on   = 1'b1;
    bit          receiver_gaps_on = 1'b1;
    // Set by a test to make the result sink hold off for that many cycles.
    int unsigned hold_off_request = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    multi_slot_alarm_timer #(
        .NUM_SLOTS  (SLOT_COUNT)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .tick_nanos   (tick_nanos),
        .target_time  (target_time),
        .delay_us     (delay_us),
        .slot_id      (slot_id),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .slot         (slot),
        .remaining_ns (remaining_ns),
        .fired_mask   (fired_mask),
        .now          (now)
    );

    // Applies one word to the shadow state and returns the result it owes.
    function automatic alarm_result_t predict_alarm(
        input logic [OP_W-1:0]   op_v,
        input logic [31:0]       nanos_v,
        input logic [TIME_W-1:0] target_v,
        input logic [31:0]       delay_v,
        input logic [ID_W-1:0]   id_v
    );
        alarm_result_t     r;
        logic [TIME_W-1:0] due;
        logic [TIME_W-1:0] delay_ns;
        bit                placed;
        int                i;
        r = '0;
        r.status = ST_OK;
        case (op_v)
            OP_TICK:
            begin
                // Clock wraps mod 2^64; armed slots whose deadline is at or before the new time fire.
                clock_ns = clock_ns + TIME_W'(nanos_v);
                for (i = 0; i < SLOT_COUNT; i++)
                begin
                    if (slot_mode[i] == MODE_ARMED && deadline_ns[i] <= clock_ns)
                    begin
                        slot_mode[i] = MODE_EXPIRED;
                        r.mask[i] = 1'b1;
                    end
                end
            end
            OP_CREATE_ABS, OP_CREATE_REL:
            begin
                delay_ns = TIME_W'(delay_v) * TIME_W'(NS_PER_US);
                if (op_v == OP_CREATE_ABS)
                    due = target_v;
                else if (delay_ns > ~clock_ns)
                    due = '1;               // saturate instead of wrapping
                else
                    due = clock_ns + delay_ns;
                if (due < clock_ns)
                    r.status = ST_PAST;
                else
                begin
                    // Lowest slot that is neither armed nor expired.
                    placed = 1'b0;
                    for (i = 0; i < SLOT_COUNT; i++)
                    begin
                        if (!placed && slot_mode[i] != MODE_ARMED &&
                            slot_mode[i] != MODE_EXPIRED)
                        begin
                            slot_mode[i]   = MODE_ARMED;
                            deadline_ns[i] = due;
                            r.slot         = SLOT_W'(i);
                            placed         = 1'b1;
                        end
                    end
                    if (!placed)
                        r.status = ST_FULL;
                end
            end
            OP_QUERY, OP_DESTROY:
            begin
                if (id_v >= SLOT_COUNT)
                    r.status = ST_INVALID;
                else if (slot_mode[id_v] != MODE_ARMED && slot_mode[id_v] != MODE_EXPIRED)
                    r.status = ST_INVALID;
                else
                begin
                    if (slot_mode[id_v] == MODE_EXPIRED)
                        r.left = '0;
                    else if (deadline_ns[id_v] <= clock_ns)
                        r.left = TIME_W'(1);  // due, waiting for the next tick
                    else
                        r.left = deadline_ns[id_v] - clock_ns;
                    if (op_v == OP_DESTROY)
                        slot_mode[id_v] = MODE_FREE;
                end
            end
            default:
                r.status = ST_INVALID;
        endcase
        r.now = clock_ns;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Result checker: every accepted result word is matched to the oldest
    // outstanding prediction.
    always @(posedge clk)
    begin
        alarm_result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result word with nothing outstanding: status %0h now %0h",
                         $time, status, now);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 64'(want.status), 64'(status));
                check_field("slot", 64'(want.slot), 64'(slot));
                check_field("remaining_ns", want.left, remaining_ns);
                check_field("fired_mask", want.mask, fired_mask);
                check_field("now", want.now, now);
            end
        end
    end

    // Result sink: random stall per word, or a long hold-off when a test asks.
    initial
    begin : result_sink
        int unsigned stall;
        out_ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (hold_off_request != 0)
            begin
                stall = hold_off_request;
                hold_off_request = 0;
            end
            else
                stall = receiver_gaps_on ? $urandom_range(0, 14) : 0;
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
        end
    end

    // Watchdog: ends the run if neither channel moves a word for too long.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_ready === 1'b1) ||
                (out_valid === 1'b1 && out_ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("multi_slot_alarm_timer_test: done, errors");
        $finish;
    end

    // Offers one word after a random gap and predicts its result on accept.
    // Valid is left high afterwards so back-to-back words need no re-raise.
    task automatic send_word(
        input logic [OP_W-1:0]   op_v,
        input logic [31:0]       nanos_v,
        input logic [TIME_W-1:0] target_v,
        input logic [31:0]       delay_v,
        input logic [ID_W-1:0]   id_v
    );
        int unsigned gap;
        gap = sender_gaps_on ? $urandom_range(0, 14) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= op_v;
        tick_nanos  <= nanos_v;
        target_time <= target_v;
        delay_us    <= delay_v;
        slot_id     <= id_v;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        pending_results.push_back(predict_alarm(op_v, nanos_v, target_v, delay_v, id_v));
    endtask

    // Sender pause: drop valid and let every outstanding result drain.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Random word biased toward deadlines near the current clock so that
    // slots actually fire, get queried while due, and get recycled.
    task automatic send_random_word();
        logic [OP_W-1:0]   op_v;
        logic [31:0]       nanos_v;
        logic [TIME_W-1:0] target_v;
        logic [31:0]       delay_v;
        logic [ID_W-1:0]   id_v;
        int unsigned       pick;
        pick     = $urandom_range(0, 99);
        nanos_v  = $urandom;
        target_v = {$urandom, $urandom};
        delay_v  = $urandom;
        id_v     = ID_W'($urandom);
        if (pick < 30)
        begin
            op_v = OP_TICK;
            case ($urandom_range(0, 9))
                0:       nanos_v = '0;
                1:       ;                       // full 32-bit step
                2:       nanos_v = $urandom_range(0, 1 << 20);
                default: nanos_v = $urandom_range(0, 2000);
            endcase
        end
        else if (pick < 45)
        begin
            op_v = OP_CREATE_ABS;
            case ($urandom_range(0, 9))
                0:       ;                       // anywhere in 64 bits
                1:       target_v = clock_ns;
                2:       target_v = clock_ns - TIME_W'($urandom_range(1, 3000));
                default: target_v = clock_ns + TIME_W'($urandom_range(0, 6000));
            endcase
        end
        else if (pick < 60)
        begin
            op_v = OP_CREATE_REL;
            if ($urandom_range(0, 9) != 0)
                delay_v = $urandom_range(0, 6);
        end
        else if (pick < 97)
        begin
            op_v = (pick < 75) ? OP_QUERY : OP_DESTROY;
            if ($urandom_range(0, 7) != 0)
                id_v = ID_W'($urandom_range(0, SLOT_COUNT - 1));
        end
        else
            op_v = OP_W'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST));
        send_word(op_v, nanos_v, target_v, delay_v, id_v);
    endtask

    // Field extremes, every op and the corner cases of deadlines and ids.
    task automatic test_directed_cases();
        send_word(OP_QUERY,   '0, '0, '0, '0);                 // free slot
        send_word(OP_DESTROY, '1, '1, '1, '1);                 // id 255
        send_word(OP_QUERY,   '0, '0, '0, ID_W'(SLOT_COUNT));  // first id past table
        send_word(OP_UNDEF_FIRST, '1, '1, '1, '1);
        send_word(OP_UNDEF_MID,   '1, '1, '1, '0);
        send_word(OP_UNDEF_LAST,  '1, '1, '1, '1);
        // Deadline equal to now is accepted, reads as due, fires on next tick.
        send_word(OP_CREATE_ABS, '1, '0, '1, '1);
        send_word(OP_QUERY, '1, '1, '1, '0);
        send_word(OP_TICK,  '0, '1, '1, '1);
        send_word(OP_QUERY, '0, '0, '0, '0);                   // expired, zero left
        send_word(OP_CREATE_REL, '0, '0, '1, '0);              // largest relative delay
        send_word(OP_CREATE_ABS, '0, '1, '0, '0);              // largest absolute deadline
        send_word(OP_CREATE_REL, '0, '0, '0, '0);              // zero delay
        send_word(OP_QUERY, '0, '0, '0, 8'd1);
        send_word(OP_TICK,  '1, '0, '0, '0);                   // largest tick
        send_word(OP_QUERY, '0, '0, '0, 8'd2);
        send_word(OP_DESTROY, '0, '0, '0, 8'd0);               // expired slot
        send_word(OP_DESTROY, '0, '0, '0, 8'd0);               // now free
        send_word(OP_CREATE_ABS, '0, '0, '0, '0);              // past deadline
        send_word(OP_CREATE_ABS, '0, clock_ns, '0, '0);        // exactly now
        send_word(OP_DESTROY, '0, '0, '0, 8'd1);
        send_word(OP_DESTROY, '0, '0, '0, 8'd2);
        send_word(OP_DESTROY, '0, '0, '0, 8'd3);
        send_word(OP_DESTROY, '0, '0, '0, 8'd0);
    endtask

    // Fill every slot, overflow the table, then tick so the short delays fire, read back and free all.
    task automatic test_table_full();
        int unsigned k;
        for (k = 0; k < SLOT_COUNT + 2; k++)
            send_word(OP_CREATE_REL, $urandom, {$urandom, $urandom},
                      $urandom_range(0, 4), ID_W'($urandom));
        // Past deadline is reported ahead of a full table.
        send_word(OP_CREATE_ABS, '0, '0, '0, '0);
        send_word(OP_TICK, 32'd2500, '0, '0, '0);
        for (k = 0; k < SLOT_COUNT; k++)
            send_word(OP_QUERY, $urandom, {$urandom, $urandom}, $urandom, ID_W'(k));
        for (k = 0; k < SLOT_COUNT; k++)
            send_word(OP_DESTROY, $urandom, {$urandom, $urandom}, $urandom, ID_W'(k));
    endtask

    // Long output hold-off while words keep coming, so the input backs up.
    task automatic test_output_stall();
        int unsigned k;
        sender_gaps_on   = 1'b0;
        hold_off_request = HOLD_OFF_CYCLES;
        for (k = 0; k < 12; k++)
            send_random_word();
        sender_gaps_on = 1'b1;
    endtask

    // Bulk random traffic with the idle patterns reshuffled now and then.
    task automatic test_random_traffic();
        int unsigned k;
        for (k = 0; k < RANDOM_WORDS; k++)
        begin
            if (k % 100 == 0)
            begin
                sender_gaps_on   = ($urandom_range(0, 3) != 0);
                receiver_gaps_on = ($urandom_range(0, 3) != 0);
            end
            if (k % 350 == 349)
                wait_for_results();
            send_random_word();
        end
    endtask

    initial
    begin : main_seq
        int i;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        op          <= OP_TICK;
        tick_nanos  <= '0;
        target_time <= '0;
        delay_us    <= '0;
        slot_id     <= '0;
        clock_ns = '0;
        for (i = 0; i < SLOT_COUNT; i++)
        begin
            slot_mode[i]   = MODE_FREE;
            deadline_ns[i] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        wait_for_results();
        test_table_full();
        test_output_stall();
        wait_for_results();
        test_random_traffic();

        // Drain, then give the pipe one more latency to show stray words.
        wait_for_results();
        repeat (LATENCY) @(posedge clk);
        if (mismatch_count == 0)
            $display("multi_slot_alarm_timer_test: done, clean");
        else
            $display("multi_slot_alarm_timer_test: done, errors");
        $finish;
    end

endmodule
